FILE: hw/rtl/tpa_pkg.sv
// Shared types and codes for the triangle primitive assembler.
package tpa_pkg;

    localparam int unsigned COORD_W = 32;

    // Request type carried in the low tuser bit
    typedef enum logic {
        REQ_BEGIN  = 1'b0,
        REQ_VERTEX = 1'b1
    } req_type_t;

    // Primitive kind chosen by a begin word
    typedef enum logic [1:0] {
        KIND_STRIP   = 2'd0,
        KIND_FAN     = 2'd1,
        KIND_LIST    = 2'd2,
        KIND_UNKNOWN = 2'd3
    } prim_kind_t;

    // Result status codes
    typedef enum logic {
        STATUS_TRIANGLE = 1'b0,
        STATUS_BAD_KIND = 1'b1
    } status_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One input word, before and after the input register
    typedef struct packed {
        req_type_t  req_type;
        prim_kind_t prim_kind;
        coord_t     vert_x;
        coord_t     vert_y;
    } item_t;

    // One result word
    typedef struct packed {
        status_t status;
        coord_t  ax;
        coord_t  ay;
        coord_t  bx;
        coord_t  by_coord;
        coord_t  cx;
        coord_t  cy;
    } tri_t;

    // Handshake from the assembly logic to the input and output stages
    typedef struct packed {
        logic take;
        logic emit;
    } asm_ctrl_t;

endpackage

FILE: hw/rtl/tpa_in_stage.sv
// Input register stage holding one accepted word.
module tpa_in_stage
    import tpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid_i,
    output logic      in_ready_o,
    input  item_t     in_item_i,
    input  asm_ctrl_t ctrl_i,
    output logic      valid_o,
    output item_t     item_o
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Refill while the held word moves on
    assign in_ready_o = !valid_reg || ctrl_i.take;
    assign accept     = in_valid_i && in_ready_o;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (ctrl_i.take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item_i;
        end
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

FILE: hw/rtl/tpa_assemble.sv
// Vertex stash, primitive kind and triangle selection.
module tpa_assemble
    import tpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      valid_i,
    input  item_t     item_i,
    input  logic      out_free_i,
    output asm_ctrl_t ctrl_o,
    output tri_t      tri_o
);

    prim_kind_t kind_reg,  kind_next;
    logic [1:0] held_reg,  held_next;
    coord_t     a_x_reg,   a_x_next;
    coord_t     a_y_reg,   a_y_next;
    coord_t     b_x_reg,   b_x_next;
    coord_t     b_y_reg,   b_y_next;
    logic       is_vertex;
    logic       bad_kind;
    logic       emit;
    logic       take;

    // Decide whether this word yields a result
    assign is_vertex = (item_i.req_type == REQ_VERTEX);
    assign bad_kind  = (kind_reg == KIND_UNKNOWN);
    assign emit      = valid_i && is_vertex && (bad_kind || (held_reg == 2'd2));
    assign take      = valid_i && (!emit || out_free_i);

    assign ctrl_o.take = take;
    assign ctrl_o.emit = emit;

    // Build the result word
    always_comb begin
        tri_o = '0;
        if (bad_kind) begin
            tri_o.status = STATUS_BAD_KIND;
        end else begin
            tri_o.status   = STATUS_TRIANGLE;
            tri_o.ax       = a_x_reg;
            tri_o.ay       = a_y_reg;
            tri_o.bx       = b_x_reg;
            tri_o.by_coord = b_y_reg;
            tri_o.cx       = item_i.vert_x;
            tri_o.cy       = item_i.vert_y;
        end
    end

    // Advance the stash when the word is taken
    always_comb begin
        kind_next = kind_reg;
        held_next = held_reg;
        a_x_next  = a_x_reg;
        a_y_next  = a_y_reg;
        b_x_next  = b_x_reg;
        b_y_next  = b_y_reg;
        if (take) begin
            if (!is_vertex) begin
                kind_next = item_i.prim_kind;
                held_next = 2'd0;
            end else if (!bad_kind) begin
                case (held_reg)
                    2'd0: begin
                        a_x_next  = item_i.vert_x;
                        a_y_next  = item_i.vert_y;
                        held_next = 2'd1;
                    end
                    2'd1: begin
                        b_x_next  = item_i.vert_x;
                        b_y_next  = item_i.vert_y;
                        held_next = 2'd2;
                    end
                    default: begin
                        if (kind_reg == KIND_LIST) begin
                            held_next = 2'd0;
                        end else begin
                            if (kind_reg == KIND_STRIP) begin
                                a_x_next = b_x_reg;
                                a_y_next = b_y_reg;
                            end
                            b_x_next = item_i.vert_x;
                            b_y_next = item_i.vert_y;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_UNKNOWN;
            held_reg <= 2'd0;
            a_x_reg  <= '0;
            a_y_reg  <= '0;
            b_x_reg  <= '0;
            b_y_reg  <= '0;
        end else begin
            kind_reg <= kind_next;
            held_reg <= held_next;
            a_x_reg  <= a_x_next;
            a_y_reg  <= a_y_next;
            b_x_reg  <= b_x_next;
            b_y_reg  <= b_y_next;
        end
    end

    // The stash never holds more than two vertices
    assert property (@(posedge aclk) disable iff (!aresetn) held_reg != 2'd3)
        else $error("held count out of range");

    // A taken begin word empties the stash
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !is_vertex) |=> (held_reg == 2'd0))
        else $error("begin did not clear stash");

    // A vertex under an unknown kind leaves the stash untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && is_vertex && bad_kind) |=> ($stable(held_reg) && $stable(a_x_reg)))
        else $error("unknown kind changed stash");

    // A stalled result holds the selection logic back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !out_free_i) |-> !take)
        else $error("result dropped on stall");

endmodule

FILE: hw/rtl/tpa_out_stage.sv
// Result register facing the downstream receiver.
module tpa_out_stage
    import tpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  asm_ctrl_t ctrl_i,
    input  tri_t      tri_i,
    output logic      out_free_o,
    output logic      out_valid_o,
    input  logic      out_ready_i,
    output tri_t      tri_o
);

    logic valid_reg;
    logic valid_next;
    tri_t tri_reg;
    logic load;

    // Free once the held result is gone or leaves this cycle
    assign out_free_o = !valid_reg || out_ready_i;
    assign load       = ctrl_i.take && ctrl_i.emit;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready_i) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tri_reg <= tri_i;
        end
    end

    assign out_valid_o = valid_reg;
    assign tri_o       = tri_reg;

endmodule

FILE: hw/rtl/triangle_primitive_assembler_core.sv
// Top level of the triangle primitive assembler.
//
// Input stream: one word per begin or vertex. s_axis_tuser selects the request
// (bit 0, 0 = begin, 1 = vertex) and on begin the primitive kind (bits 2:1,
// strip, fan, list, unknown). s_axis_tdata carries the vertex x and y.
// Output stream: one word per assembled triangle, or a status word with
// m_axis_tuser set for a vertex that arrives under an unknown kind. Begin
// words and the first two vertices of a strip, fan or list give no output.
// A word is registered on input and its result is registered on output.
// Throughput: one word per cycle while the result register is free; the stash
// update is a single mux and register write, so the input register is refilled
// every cycle unless a result word waits for a busy result register.
// Reset (aresetn low, synchronous) empties both stages, clears the stash and
// sets the kind to unknown.
// When the receiver stalls the result register holds; the input register
// keeps taking words that produce no output, and backs up when the next one
// needs the result register.
module triangle_primitive_assembler_core
    import tpa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // vert_x, vert_y
    input  logic [2:0]   s_axis_tuser,   // req_type, prim_kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // ax, ay, bx, by_coord, cx, cy
    output logic [0:0]   m_axis_tuser    // status
);

    item_t     in_item;
    item_t     held_item;
    logic      held_valid;
    asm_ctrl_t ctrl;
    tri_t      tri_comb;
    tri_t      tri_out;
    logic      out_free;

    // Unpack the input word
    always_comb begin
        in_item.req_type  = req_type_t'(s_axis_tuser[0]);
        in_item.prim_kind = prim_kind_t'(s_axis_tuser[2:1]);
        in_item.vert_x    = s_axis_tdata[31:0];
        in_item.vert_y    = s_axis_tdata[63:32];
    end

    tpa_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (s_axis_tvalid),
        .in_ready_o (s_axis_tready),
        .in_item_i  (in_item),
        .ctrl_i     (ctrl),
        .valid_o    (held_valid),
        .item_o     (held_item)
    );

    tpa_assemble u_assemble (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .valid_i    (held_valid),
        .item_i     (held_item),
        .out_free_i (out_free),
        .ctrl_o     (ctrl),
        .tri_o      (tri_comb)
    );

    tpa_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl_i      (ctrl),
        .tri_i       (tri_comb),
        .out_free_o  (out_free),
        .out_valid_o (m_axis_tvalid),
        .out_ready_i (m_axis_tready),
        .tri_o       (tri_out)
    );

    // Pack the result word, ax in the lowest bits
    assign m_axis_tdata = {tri_out.cy, tri_out.cx, tri_out.by_coord,
                           tri_out.bx, tri_out.ay, tri_out.ax};
    assign m_axis_tuser = tri_out.status;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the triangle primitive assembler: directed table, then random primitives.
`timescale 1ns / 100ps

module tb_top;
    import tpa_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam coord_t      C_MAX        = 32'sh7FFF_FFFF;
    localparam coord_t      C_MIN        = 32'sh8000_0000;
    localparam tri_t        BAD_KIND_WORD = '{status: STATUS_BAD_KIND, default: '0};

    // One row of the directed table; want is used only where typed is set
    typedef struct {
        req_type_t  req;
        prim_kind_t kind;
        coord_t     x;
        coord_t     y;
        bit         typed;
        tri_t       want;
    } dir_row_t;

    localparam int unsigned DIR_ROWS = 23;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata  = '0;   // vert_x, vert_y
    logic [2:0]   s_axis_tuser  = '0;   // req_type, prim_kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;         // ax, ay, bx, by_coord, cx, cy
    logic [0:0]   m_axis_tuser;         // status

    // Idle percentages of the current phase
    int unsigned send_idle  = 0;
    int unsigned recv_stall = 0;

    // Long receiver hold-off, requested by the stimulus and counted by the receiver
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned cycle_count = 0;
    int unsigned err_count   = 0;
    int unsigned words_sent  = 0;

    // Shadow of the assembler state
    prim_kind_t kind_now    = KIND_UNKNOWN;
    logic [1:0] stash_count = '0;
    coord_t     stash_a_x   = '0;
    coord_t     stash_a_y   = '0;
    coord_t     stash_b_x   = '0;
    coord_t     stash_b_y   = '0;

    tri_t       pending_triangles [$];
    string      coord_names [6] = '{"ax", "ay", "bx", "by_coord", "cx", "cy"};
    dir_row_t   dir_rows [DIR_ROWS];

    triangle_primitive_assembler_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Advance the shadow state by one word and return the triangle it closes, if any
    task automatic assemble_triangle(input item_t w, output bit made, output tri_t exp_tri);
        made    = 1'b0;
        exp_tri = '0;
        if (w.req_type == REQ_BEGIN) begin
            kind_now    = w.prim_kind;
            stash_count = 2'd0;
        end else if (kind_now == KIND_UNKNOWN) begin
            made    = 1'b1;
            exp_tri = BAD_KIND_WORD;
        end else if (stash_count == 2'd0) begin
            stash_a_x   = w.vert_x;
            stash_a_y   = w.vert_y;
            stash_count = 2'd1;
        end else if (stash_count == 2'd1) begin
            stash_b_x   = w.vert_x;
            stash_b_y   = w.vert_y;
            stash_count = 2'd2;
        end else begin
            made    = 1'b1;
            exp_tri = '{STATUS_TRIANGLE, stash_a_x, stash_a_y, stash_b_x, stash_b_y,
                        w.vert_x, w.vert_y};
            if (kind_now == KIND_LIST) begin
                stash_count = 2'd0;
            end else begin
                // strip slides the window, fan keeps its center in slot A
                if (kind_now == KIND_STRIP) begin
                    stash_a_x = stash_b_x;
                    stash_a_y = stash_b_y;
                end
                stash_b_x = w.vert_x;
                stash_b_y = w.vert_y;
            end
        end
    endtask

    // Offer one word after an optional gap and wait for the handshake
    task automatic offer_word(input item_t w);
        if ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.vert_y, w.vert_x};
        s_axis_tuser  <= {w.prim_kind, w.req_type};
        @(posedge aclk);
        while (s_axis_tready !== 1'b1) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_predicted(input item_t w);
        bit   made;
        tri_t exp_tri;
        offer_word(w);
        assemble_triangle(w, made, exp_tri);
        if (made) pending_triangles.push_back(exp_tri);
    endtask

    // Mostly random coordinates, with the extremes mixed in
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 15))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return '1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic item_t make_vertex();
        item_t w;
        w.req_type  = REQ_VERTEX;
        w.prim_kind = prim_kind_t'($urandom_range(0, 3));
        w.vert_x    = pick_coord();
        w.vert_y    = pick_coord();
        return w;
    endfunction

    function automatic item_t make_begin(input prim_kind_t kind);
        item_t w;
        w.req_type  = REQ_BEGIN;
        w.prim_kind = kind;
        w.vert_x    = coord_t'($urandom);
        w.vert_y    = coord_t'($urandom);
        return w;
    endfunction

    // Mostly well-formed primitives, some stray begins and lone vertices
    task automatic run_random(input int unsigned target);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n_vert;
        prim_kind_t  kind;
        stop_at = words_sent + target;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                pick = $urandom_range(0, 99);
                if (pick < 32)      kind = KIND_STRIP;
                else if (pick < 64) kind = KIND_FAN;
                else if (pick < 94) kind = KIND_LIST;
                else                kind = KIND_UNKNOWN;
                send_predicted(make_begin(kind));
                n_vert = $urandom_range(1, 12);
                repeat (n_vert) send_predicted(make_vertex());
            end else if (pick < 93) begin
                send_predicted(make_begin(prim_kind_t'($urandom_range(0, 3))));
            end else begin
                send_predicted(make_vertex());
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen     <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Compare every accepted result word with the oldest expectation
    always @(posedge aclk) begin : result_check
        tri_t   want;
        coord_t want_c [6];
        coord_t got_c;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_triangles.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d data=%h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                want      = pending_triangles.pop_front();
                want_c[0] = want.ax;
                want_c[1] = want.ay;
                want_c[2] = want.bx;
                want_c[3] = want.by_coord;
                want_c[4] = want.cx;
                want_c[5] = want.cy;
                if (m_axis_tuser[0] !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tuser[0], want.status));
                for (int k = 0; k < 6; k++) begin
                    got_c = m_axis_tdata[32*k +: 32];
                    if (got_c !== want_c[k])
                        report_mismatch($sformatf("%s got %h want %h",
                                                  coord_names[k], got_c, want_c[k]));
                end
            end
        end
    end

    initial begin : stimulus
        item_t w;
        bit    made;
        tri_t  exp_tri;

        // Vertices before any begin, extremes, each kind, begin mid-primitive
        dir_rows = '{
            '{REQ_VERTEX, KIND_LIST,    C_MAX, C_MIN, 1'b1, BAD_KIND_WORD},
            '{REQ_BEGIN,  KIND_UNKNOWN, C_MIN, C_MAX, 1'b0, '0},
            '{REQ_VERTEX, KIND_STRIP,   '0,    '1,    1'b1, BAD_KIND_WORD},
            '{REQ_BEGIN,  KIND_STRIP,   C_MAX, C_MAX, 1'b0, '0},
            '{REQ_VERTEX, KIND_FAN,     C_MAX, C_MIN, 1'b0, '0},
            '{REQ_VERTEX, KIND_UNKNOWN, C_MIN, C_MAX, 1'b0, '0},
            '{REQ_VERTEX, KIND_STRIP,   '0,    '1,    1'b1,
              '{STATUS_TRIANGLE, C_MAX, C_MIN, C_MIN, C_MAX, '0, '1}},
            '{REQ_VERTEX, KIND_LIST,    '1,    '0,    1'b0, '0},
            '{REQ_BEGIN,  KIND_FAN,     '1,    '1,    1'b0, '0},
            '{REQ_VERTEX, KIND_FAN,     32'sd1, 32'sd2, 1'b0, '0},
            '{REQ_VERTEX, KIND_FAN,     32'sd3, 32'sd4, 1'b0, '0},
            '{REQ_VERTEX, KIND_FAN,     32'sd5, 32'sd6, 1'b0, '0},
            '{REQ_VERTEX, KIND_FAN,     32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, '0},
            '{REQ_BEGIN,  KIND_LIST,    '0,    '0,    1'b0, '0},
            '{REQ_VERTEX, KIND_LIST,    -32'sd7, 32'sd8, 1'b0, '0},
            '{REQ_VERTEX, KIND_LIST,    C_MAX, C_MAX, 1'b0, '0},
            '{REQ_VERTEX, KIND_LIST,    C_MIN, C_MIN, 1'b0, '0},
            '{REQ_VERTEX, KIND_LIST,    32'sd9, -32'sd9, 1'b0, '0},
            '{REQ_BEGIN,  KIND_STRIP,   C_MIN, C_MIN, 1'b0, '0},
            '{REQ_VERTEX, KIND_STRIP,   32'sd10, 32'sd11, 1'b0, '0},
            '{REQ_VERTEX, KIND_STRIP,   32'sd12, 32'sd13, 1'b0, '0},
            '{REQ_BEGIN,  KIND_UNKNOWN, '0,    '0,    1'b0, '0},
            '{REQ_VERTEX, KIND_FAN,     32'sd14, 32'sd15, 1'b1, BAD_KIND_WORD}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (dir_rows[i]) begin
            w.req_type  = dir_rows[i].req;
            w.prim_kind = dir_rows[i].kind;
            w.vert_x    = dir_rows[i].x;
            w.vert_y    = dir_rows[i].y;
            offer_word(w);
            assemble_triangle(w, made, exp_tri);
            if (dir_rows[i].typed)      pending_triangles.push_back(dir_rows[i].want);
            else if (made)              pending_triangles.push_back(exp_tri);
        end

        // Hold the receiver off while a strip streams in back to back
        send_predicted(make_begin(KIND_STRIP));
        hold_reqs <= hold_reqs + 1;
        repeat (40) send_predicted(make_vertex());
        run_random(260);

        send_idle  <= 83;
        recv_stall <= 0;
        run_random(300);

        send_idle  <= 0;
        recv_stall <= 83;
        run_random(300);

        send_idle  <= 27;
        recv_stall <= 27;
        run_random(300);

        s_axis_tvalid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_triangles.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
